FILE: rtl/core/bed_pkg.sv
package bed_pkg;

    // one input transfer
    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
    } t_in;

    // one result transfer
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       stop_seen;
        logic       end_marker;
        logic       last;
    } t_out;

    // up to two results raised by one input item
    typedef struct packed {
        logic [1:0] count;
        t_out       res0;
        t_out       res1;
    } t_dec_res;

    // request kinds
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_EOS  = 1'b1;

    // character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_STOP   = 8'h63;

    // control bytes
    localparam logic [7:0] CTL_BEL = 8'd7;
    localparam logic [7:0] CTL_BS  = 8'd8;
    localparam logic [7:0] CTL_HT  = 8'd9;
    localparam logic [7:0] CTL_LF  = 8'd10;
    localparam logic [7:0] CTL_VT  = 8'd11;
    localparam logic [7:0] CTL_FF  = 8'd12;
    localparam logic [7:0] CTL_CR  = 8'd13;
    localparam logic [7:0] CTL_ESC = 8'd27;

    // escape letter to control byte, bit 8 flags a known escape
    function automatic logic [8:0] escape_code(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h61:     r = {1'b1, CTL_BEL};  // a
            8'h62:     r = {1'b1, CTL_BS};   // b
            8'h65:     r = {1'b1, CTL_ESC};  // e
            8'h66:     r = {1'b1, CTL_FF};   // f
            8'h6E:     r = {1'b1, CTL_LF};   // n
            8'h72:     r = {1'b1, CTL_CR};   // r
            8'h74:     r = {1'b1, CTL_HT};   // t
            8'h76:     r = {1'b1, CTL_VT};   // v
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

    // result record carrying a data byte
    function automatic t_out make_byte(input logic [7:0] b);
        t_out r;
        r            = '0;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

endpackage

FILE: rtl/core/backslash_escape_decoder.sv
// Echo-style backslash escape decoder.
// Input channel: i_in_valid / o_in_ready carry one t_in per transfer, either a
// character byte or an end-of-string request. Output channel: o_out_valid /
// i_out_ready carry one t_out per transfer; the last result raised by an item
// has last set. An item raises zero, one or two results.
// Results of an item are registered into the result queue at its transfer, behind any results already held.
// Throughput: one item per cycle while the receiver keeps up; items raising
// two results drain at one result per cycle, set by the single output port of
// the four-entry result queue.
// o_in_ready is high while the queue holds two or fewer results, so a stalled
// receiver backs up into the input after the queue fills; nothing is dropped.
// i_cfg_we writes escape_enable (bit 0 of i_cfg_data) into a register; the user
// must change it only while the block is idle, the block does not enforce this.
// Reset (synchronous, active low): parser back to normal phase, octal
// accumulator and stop flag cleared, queue emptied, escapes enabled.
module backslash_escape_decoder
    import bed_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data,
    input  logic i_cfg_we,
    input  logic i_cfg_data
);

    logic     r_esc_en;
    logic     take;
    t_dec_res dec_res;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_esc_en <= i_cfg_data;
        end
    end

    // input transfer
    assign take = i_in_valid && o_in_ready;

    bed_dec u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (i_in_data),
        .i_esc_en (r_esc_en),
        .o_res    (dec_res)
    );

    bed_oq u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (dec_res),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

FILE: rtl/core/bed_dec.sv
module bed_dec
    import bed_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_in      i_item,
    input  logic     i_esc_en,
    output t_dec_res o_res
);

    typedef enum logic [2:0] {
        PH_NORMAL = 3'b001,
        PH_BSLASH = 3'b010,
        PH_OCTAL  = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [8:0] r_oct, n_oct;
    logic [1:0] r_dig, n_dig;
    logic       r_stop, n_stop;

    // decode of one item into up to two bytes and an end marker
    always_comb begin
        logic       pend_v;
        logic [7:0] pend_b;
        logic       e0_v, e1_v, em;
        logic [7:0] e0_b, e1_b, c;
        logic [8:0] esc, nv;
        logic [1:0] cnt;
        t_out       mark;

        c       = i_item.char_code;
        n_phase = r_phase;
        n_oct   = r_oct;
        n_dig   = r_dig;
        n_stop  = r_stop;
        e0_v    = 1'b0;
        e0_b    = '0;
        e1_v    = 1'b0;
        e1_b    = '0;
        em      = 1'b0;
        esc     = escape_code(c);
        nv      = {r_oct[5:0], c[2:0]};

        // pending backslash or octal value
        case (r_phase)
            PH_BSLASH: begin
                pend_v = 1'b1;
                pend_b = CH_BSLASH;
            end
            PH_OCTAL: begin
                pend_v = 1'b1;
                pend_b = r_oct[7:0];
            end
            default: begin
                pend_v = 1'b0;
                pend_b = '0;
            end
        endcase

        if (i_item.req_type == REQ_EOS) begin
            e0_v    = pend_v;
            e0_b    = pend_b;
            em      = 1'b1;
            n_phase = PH_NORMAL;
            n_oct   = '0;
            n_dig   = '0;
            n_stop  = 1'b0;
        end else if (r_stop) begin
            // dropped until end of string
        end else if (!i_esc_en) begin
            e0_v    = pend_v;
            e0_b    = pend_b;
            e1_v    = 1'b1;
            e1_b    = c;
            n_phase = PH_NORMAL;
            n_oct   = '0;
            n_dig   = '0;
        end else begin
            case (r_phase)
                PH_BSLASH: begin
                    n_phase = PH_NORMAL;
                    if (esc[8]) begin
                        e0_v = 1'b1;
                        e0_b = esc[7:0];
                    end else if (c == CH_STOP) begin
                        n_stop = 1'b1;
                    end else if (c == CH_ZERO) begin
                        n_phase = PH_OCTAL;
                        n_oct   = '0;
                        n_dig   = '0;
                    end else begin
                        e0_v = 1'b1;
                        e0_b = CH_BSLASH;
                        e1_v = 1'b1;
                        e1_b = c;
                    end
                end
                PH_OCTAL: begin
                    if ((c inside {[CH_ZERO:CH_SEVEN]}) && r_dig != 2'd3) begin
                        n_oct = nv;
                        n_dig = r_dig + 2'd1;
                        // third digit closes the escape
                        if (r_dig == 2'd2) begin
                            e0_v    = 1'b1;
                            e0_b    = nv[7:0];
                            n_phase = PH_NORMAL;
                            n_oct   = '0;
                            n_dig   = '0;
                        end
                    end else begin
                        e0_v  = 1'b1;
                        e0_b  = r_oct[7:0];
                        n_oct = '0;
                        n_dig = '0;
                        if (c == CH_BSLASH) begin
                            n_phase = PH_BSLASH;
                        end else begin
                            n_phase = PH_NORMAL;
                            e1_v    = 1'b1;
                            e1_b    = c;
                        end
                    end
                end
                default: begin
                    if (c == CH_BSLASH) begin
                        n_phase = PH_BSLASH;
                    end else begin
                        e0_v = 1'b1;
                        e0_b = c;
                    end
                end
            endcase
        end

        // pack results in order, at most two
        mark            = '0;
        mark.stop_seen  = r_stop;
        mark.end_marker = 1'b1;
        o_res           = '0;
        cnt             = 2'd0;
        if (e0_v) begin
            o_res.res0 = make_byte(e0_b);
            cnt        = 2'd1;
        end
        if (e1_v) begin
            if (cnt == 2'd0) begin
                o_res.res0 = make_byte(e1_b);
            end else begin
                o_res.res1 = make_byte(e1_b);
            end
            cnt = cnt + 2'd1;
        end
        if (em) begin
            if (cnt == 2'd0) begin
                o_res.res0 = mark;
            end else begin
                o_res.res1 = mark;
            end
            cnt = cnt + 2'd1;
        end
        if (cnt == 2'd2) begin
            o_res.res1.last = 1'b1;
        end else if (cnt == 2'd1) begin
            o_res.res0.last = 1'b1;
        end
        o_res.count = i_take ? cnt : 2'd0;
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_oct   <= '0;
            r_dig   <= '0;
            r_stop  <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_oct   <= n_oct;
            r_dig   <= n_dig;
            r_stop  <= n_stop;
        end
    end

endmodule

FILE: rtl/core/bed_oq.sv
module bed_oq
    import bed_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dec_res i_res,
    output logic     o_room,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out     o_data
);

    t_out       r_mem [4];
    logic [1:0] r_head, n_head;
    logic [1:0] r_tail, n_tail;
    logic [2:0] r_count, n_count;
    logic       pop;

    // room for two more results whatever the receiver does
    assign o_room  = (r_count <= 3'd2);
    assign o_valid = (r_count != 3'd0);
    assign o_data  = r_mem[r_head];
    assign pop     = o_valid && i_ready;

    // pointer and fill level update
    always_comb begin
        n_head  = r_head + {1'b0, pop};
        n_tail  = r_tail + i_res.count;
        n_count = r_count + {1'b0, i_res.count} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_res.count != 2'd0) begin
            r_mem[r_tail] <= i_res.res0;
        end
        if (i_res.count == 2'd2) begin
            r_mem[r_tail + 2'd1] <= i_res.res1;
        end
    end

endmodule
